[rtl/rfd_pkg.sv]
// Shared constants and types for the RTCM3 deframer with CRC-24Q check.
`timescale 1ns / 1ps

package rfd_pkg;

    localparam int unsigned COUNTER_BITS_DEFAULT = 32;

    localparam logic [7:0]  PREAMBLE    = 8'hD3;
    localparam logic [7:0]  LEN_HI_MASK = 8'h03;
    localparam logic [23:0] CRC_POLY    = 24'h864CFB;

    localparam int unsigned OUT_COUNT_BITS = 32;

    // Per-byte result handed from the core to the output register.
    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        in_frame;
        logic        frame_last;
        logic        crc_ok;
        logic [11:0] message_type;
        logic [9:0]  payload_length;
        logic [OUT_COUNT_BITS-1:0] good_frames;
        logic [OUT_COUNT_BITS-1:0] crc_error_frames;
    } rfd_result_t;

endpackage

[rtl/rfd_crc24q.sv]
// Byte-wide CRC-24Q update, MSB first.
`timescale 1ns / 1ps

module rfd_crc24q
(
    input  logic [23:0] crc_in,
    input  logic [7:0]  data,
    output logic [23:0] crc_out
);

    always_comb
    begin
        logic [23:0] c;
        c = crc_in ^ {data, 16'h0000};
        for (int i = 0; i < 8; i++)
        begin
            if (c[23])
            begin
                c = {c[22:0], 1'b0} ^ rfd_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[22:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[rtl/rfd_core.sv]
// Frame tracking state, CRC accumulation and frame counters.
`timescale 1ns / 1ps

module rfd_core
#(
    parameter int unsigned COUNTER_BITS = rfd_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output rfd_pkg::rfd_result_t result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [10:0]             bytes_seen_reg, bytes_seen_next;
    logic [9:0]              length_held_reg, length_held_next;
    logic [23:0]             crc_running_reg, crc_running_next;
    logic [23:0]             crc_received_reg, crc_received_next;
    logic [11:0]             type_held_reg, type_held_next;
    logic [COUNTER_BITS-1:0] good_count_reg, good_count_next;
    logic [COUNTER_BITS-1:0] error_count_reg, error_count_next;

    logic [23:0] crc_seed;
    logic [23:0] crc_stepped;
    logic [10:0] crc_end;
    logic [10:0] frame_end;
    logic [63:0] good_wide;
    logic [63:0] error_wide;

    assign crc_seed = (phase_reg == PH_HUNT) ? 24'h000000 : crc_running_reg;

    rfd_crc24q u_crc
    (
        .crc_in  (crc_seed),
        .data    (rx_byte),
        .crc_out (crc_stepped)
    );

    assign crc_end   = 11'(length_held_reg) + 11'd3;
    assign frame_end = 11'(length_held_reg) + 11'd5;

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_seen_next   = bytes_seen_reg;
        length_held_next  = length_held_reg;
        crc_running_next  = crc_running_reg;
        crc_received_next = crc_received_reg;
        type_held_next    = type_held_reg;
        good_count_next   = good_count_reg;
        error_count_next  = error_count_reg;

        result.echo_byte      = rx_byte;
        result.in_frame       = 1'b1;
        result.frame_last     = 1'b0;
        result.crc_ok         = 1'b0;
        result.message_type   = '0;
        result.payload_length = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == rfd_pkg::PREAMBLE)
                begin
                    crc_running_next  = crc_stepped;
                    crc_received_next = '0;
                    type_held_next    = '0;
                    length_held_next  = '0;
                    bytes_seen_next   = 11'd1;
                    phase_next        = PH_HEADER;
                end
                else
                begin
                    result.in_frame = 1'b0;
                end
            end
            PH_HEADER:
            begin
                crc_running_next = crc_stepped;
                if (bytes_seen_reg == 11'd1)
                begin
                    length_held_next = {rx_byte[1:0] & rfd_pkg::LEN_HI_MASK[1:0], 8'h00};
                    bytes_seen_next  = 11'd2;
                end
                else
                begin
                    length_held_next = {length_held_reg[9:8], rx_byte};
                    bytes_seen_next  = 11'd3;
                    phase_next       = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (bytes_seen_reg == 11'd3)
                begin
                    type_held_next = {rx_byte, 4'h0};
                end
                else if (bytes_seen_reg == 11'd4)
                begin
                    type_held_next = {type_held_reg[11:4], rx_byte[7:4]};
                end

                if (bytes_seen_reg < crc_end)
                begin
                    crc_running_next = crc_stepped;
                end
                else
                begin
                    crc_received_next = {crc_received_reg[15:0], rx_byte};
                end

                if (bytes_seen_reg >= frame_end)
                begin
                    result.frame_last     = 1'b1;
                    result.crc_ok         = (crc_running_next == crc_received_next);
                    result.message_type   = type_held_next;
                    result.payload_length = length_held_reg;
                    if (crc_running_next == crc_received_next)
                    begin
                        good_count_next = good_count_reg + COUNTER_BITS'(1);
                    end
                    else
                    begin
                        error_count_next = error_count_reg + COUNTER_BITS'(1);
                    end
                    phase_next      = PH_HUNT;
                    bytes_seen_next = '0;
                end
                else
                begin
                    bytes_seen_next = bytes_seen_reg + 11'd1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        good_wide               = 64'(good_count_next);
        error_wide              = 64'(error_count_next);
        result.good_frames      = good_wide[rfd_pkg::OUT_COUNT_BITS-1:0];
        result.crc_error_frames = error_wide[rfd_pkg::OUT_COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            bytes_seen_reg   <= '0;
            length_held_reg  <= '0;
            crc_running_reg  <= '0;
            crc_received_reg <= '0;
            type_held_reg    <= '0;
            good_count_reg   <= '0;
            error_count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            bytes_seen_reg   <= bytes_seen_next;
            length_held_reg  <= length_held_next;
            crc_running_reg  <= crc_running_next;
            crc_received_reg <= crc_received_next;
            type_held_reg    <= type_held_next;
            good_count_reg   <= good_count_next;
            error_count_reg  <= error_count_next;
        end
    end

endmodule

[rtl/rtcm3_frame_deframer_crc24q_unit.sv]
// Top level of the RTCM3 frame deframer with CRC-24Q check.
`timescale 1ns / 1ps

// Takes one received byte per input beat and returns one output beat per
// byte: the byte itself, tagged with whether it belongs to a frame
// (tuser) and whether it is the last CRC byte of a frame (tlast). Bytes
// other than the preamble 0xD3 are dropped from framing while hunting but
// still echoed with tuser low. The header gives a 10-bit payload length; a
// frame is length + 6 bytes. CRC-24Q (poly 0x864CFB, init 0) covers the
// preamble, header and payload and is compared against the three trailing
// bytes. On the last byte the beat carries crc_ok, the 12-bit message type
// and the length; elsewhere those fields are zero. The good-frame and
// CRC-error counters wrap at 2^COUNTER_BITS and every beat carries their
// low 32 bits. A bad frame is consumed whole; hunting resumes after it.
// Throughput is one byte per cycle; a byte's beat appears in the cycle
// after it is taken: the byte-wide CRC step and frame state update sit
// between the state registers and a single output register, and a new
// byte is taken whenever that register is empty or drained in the same cycle.

module rtcm3_frame_deframer_crc24q_unit
#(
    parameter int unsigned COUNTER_BITS = rfd_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] echo_byte, [8] crc_ok, [20:9] message_type, [30:21] payload_length,
    // [62:31] good_frames, [94:63] crc_error_frames, [95] zero
    output logic [95:0] m_tdata,
    output logic        m_tuser,   // [0] in_frame
    output logic        m_tlast    // frame_last
);

    logic                 accept;
    rfd_pkg::rfd_result_t result;
    rfd_pkg::rfd_result_t result_reg;
    logic                 out_valid_reg;

    // Take a beat whenever the output register is free or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    rfd_core
    #(
        .COUNTER_BITS (COUNTER_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .result  (result)
    );

    // Output register: hold the valid flag under reset control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset; advance it with each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.in_frame;
    assign m_tlast  = result_reg.frame_last;
    assign m_tdata  = {1'b0,
                       result_reg.crc_error_frames,
                       result_reg.good_frames,
                       result_reg.payload_length,
                       result_reg.message_type,
                       result_reg.crc_ok,
                       result_reg.echo_byte};

endmodule

[bench/rfd_tb_pkg.sv]
// CRC-24Q byte step shared by the frame builder and the frame predictor.
`timescale 1ns / 1ps

package rfd_tb_pkg;

    // Advance CRC-24Q by one byte, MSB first, no final xor.
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                                input logic [7:0]  data);
        logic [23:0] crc;
        crc = crc_in ^ {data, 16'h0000};
        for (int i = 0; i < 8; i++)
        begin
            crc = crc[23] ? ((crc << 1) ^ rfd_pkg::CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

endpackage

[bench/rfd_frame_checker.sv]
// Beat monitor with frame predictor and result comparison for the deframer.
`timescale 1ns / 1ps

module rfd_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    import rfd_pkg::*;
    import rfd_tb_pkg::*;

    typedef enum logic [1:0] {HUNT, HEADER, BODY} frame_phase_e;

    frame_phase_e phase;
    logic [10:0]  byte_index;
    logic [9:0]   length_acc;
    logic [23:0]  crc_calc;
    logic [23:0]  crc_trailer;
    logic [11:0]  type_acc;
    logic [31:0]  good_total;
    logic [31:0]  bad_total;

    rfd_result_t  expected_q[$];
    int           beat_count;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        beat_count  = 0;
    end

    // Work out the output beat for one accepted byte and advance the frame state.
    task automatic predict_beat(input logic [7:0] b, output rfd_result_t r);
        r = '0;
        r.echo_byte = b;
        r.in_frame  = 1'b1;
        case (phase)
            HUNT:
            begin
                if (b == PREAMBLE)
                begin
                    crc_calc    = crc24q_byte(24'h000000, b);
                    crc_trailer = '0;
                    type_acc    = '0;
                    length_acc  = '0;
                    byte_index  = 11'd1;
                    phase       = HEADER;
                end
                else
                begin
                    r.in_frame = 1'b0;
                end
            end
            HEADER:
            begin
                crc_calc = crc24q_byte(crc_calc, b);
                if (byte_index == 11'd1)
                begin
                    length_acc = {b[1:0] & LEN_HI_MASK[1:0], 8'h00};
                    byte_index = 11'd2;
                end
                else
                begin
                    length_acc = length_acc | {2'b00, b};
                    byte_index = 11'd3;
                    phase      = BODY;
                end
            end
            default:
            begin
                // Message type comes from frame bytes 3 and 4, CRC bytes or not.
                if (byte_index == 11'd3)
                    type_acc = {b, 4'h0};
                else if (byte_index == 11'd4)
                    type_acc = type_acc | {8'h00, b[7:4]};

                if (int'(byte_index) < int'(length_acc) + 3)
                    crc_calc = crc24q_byte(crc_calc, b);
                else
                    crc_trailer = {crc_trailer[15:0], b};

                if (int'(byte_index) >= int'(length_acc) + 5)
                begin
                    r.frame_last     = 1'b1;
                    r.crc_ok         = (crc_calc == crc_trailer);
                    r.message_type   = type_acc;
                    r.payload_length = length_acc;
                    if (r.crc_ok)
                        good_total = good_total + 32'd1;
                    else
                        bad_total = bad_total + 32'd1;
                    phase      = HUNT;
                    byte_index = '0;
                end
                else
                begin
                    byte_index = byte_index + 11'd1;
                end
            end
        endcase
        r.good_frames      = good_total;
        r.crc_error_frames = bad_total;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("output beat %0d: %s expected %0h, got %0h",
                     beat_count, field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rfd_result_t want;
        rfd_result_t got;
        if (!rst_n)
        begin
            phase       = HUNT;
            byte_index  = '0;
            length_acc  = '0;
            crc_calc    = '0;
            crc_trailer = '0;
            type_acc    = '0;
            good_total  = '0;
            bad_total   = '0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_beat(s_tdata, want);
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                beat_count++;
                got.echo_byte        = m_tdata[7:0];
                got.in_frame         = m_tuser;
                got.frame_last       = m_tlast;
                got.crc_ok           = m_tdata[8];
                got.message_type     = m_tdata[20:9];
                got.payload_length   = m_tdata[30:21];
                got.good_frames      = m_tdata[62:31];
                got.crc_error_frames = m_tdata[94:63];
                if (expected_q.size() == 0)
                begin
                    note_mismatch("unexpected beat, echo_byte", '0, 32'(got.echo_byte));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.echo_byte !== want.echo_byte)
                        note_mismatch("echo_byte", 32'(want.echo_byte),
                                      32'(got.echo_byte));
                    if (got.in_frame !== want.in_frame)
                        note_mismatch("in_frame", 32'(want.in_frame), 32'(got.in_frame));
                    if (got.frame_last !== want.frame_last)
                        note_mismatch("frame_last", 32'(want.frame_last),
                                      32'(got.frame_last));
                    if (got.crc_ok !== want.crc_ok)
                        note_mismatch("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
                    if (got.message_type !== want.message_type)
                        note_mismatch("message_type", 32'(want.message_type),
                                      32'(got.message_type));
                    if (got.payload_length !== want.payload_length)
                        note_mismatch("payload_length", 32'(want.payload_length),
                                      32'(got.payload_length));
                    if (got.good_frames !== want.good_frames)
                        note_mismatch("good_frames", want.good_frames, got.good_frames);
                    if (got.crc_error_frames !== want.crc_error_frames)
                        note_mismatch("crc_error_frames", want.crc_error_frames,
                                      got.crc_error_frames);
                    if (m_tdata[95] !== 1'b0)
                        note_mismatch("pad bit", 32'd0, 32'(m_tdata[95]));
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

[bench/tb_rtcm3_frame_deframer_crc24q_unit.sv]
// Stimulus and verdict for the RTCM3 deframer with CRC-24Q check.
`timescale 1ns / 1ps

module tb_rtcm3_frame_deframer_crc24q_unit;

    import rfd_pkg::*;
    import rfd_tb_pkg::*;

    // Slowest run sends ~500 bytes; this limit leaves ample margin.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Minimum random bytes per phase, not counting the one long frame.
    localparam int PHASE_BYTES = 50;
    // Payload of the long frame; sets the upper length bits in the header.
    localparam int LONG_LENGTH = 260;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] echo_byte, [8] crc_ok, [20:9] message_type, [30:21] payload_length,
    // [62:31] good_frames, [94:63] crc_error_frames, [95] zero
    logic [95:0] m_tdata;
    logic        m_tuser;    // [0] in_frame
    logic        m_tlast;    // frame_last

    int          mismatches;
    int          outstanding;
    int          src_idle_pct;
    int          rcv_idle_pct;
    int          bytes_sent = 0;
    int unsigned cycle_count = 0;

    always #5 clk = ~clk;

    rtcm3_frame_deframer_crc24q_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rfd_frame_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Stall the output side at random; the rate follows the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one byte and return right after the edge that takes it. Leave
    // tvalid high on return so back-to-back beats never drop it; idle gaps
    // are inserted before the beat. s_tready is read at the falling edge,
    // where it has settled and stays put until the next rising edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    // Build one frame with a valid trailer, then optionally flip one bit after
    // the header (bad CRC) and drop the last cut bytes (truncated frame). The
    // six ignored header bits are random so the block must mask them.
    task automatic send_frame(input int len, input bit corrupt, input bit fill_preamble,
                              input int cut);
        logic [7:0]  frame_q[$];
        logic [23:0] crc;
        int          pos;
        frame_q.push_back(PREAMBLE);
        frame_q.push_back(8'($urandom_range(63) << 2) | (8'(len >> 8) & LEN_HI_MASK));
        frame_q.push_back(8'(len));
        for (int i = 0; i < len; i++)
            frame_q.push_back(fill_preamble ? PREAMBLE : 8'($urandom_range(255)));
        crc = '0;
        foreach (frame_q[i])
            crc = crc24q_byte(crc, frame_q[i]);
        frame_q.push_back(crc[23:16]);
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
        if (corrupt)
        begin
            pos = $urandom_range(frame_q.size() - 1, 3);
            frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(7));
        end
        for (int i = 0; i < frame_q.size() - cut; i++)
            send_byte(frame_q[i]);
    endtask

    // Mostly short payloads keep frames frequent; some run a bit longer.
    function automatic int short_length();
        return ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
    endfunction

    // One random unit: mostly good frames, then bad-CRC frames, line noise
    // and the odd truncated frame that swallows the start of the next one.
    task automatic random_unit();
        int          pick;
        int          n;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            send_frame(short_length(), 1'b0, 1'b0, 0);
        end
        else if (pick < 82)
        begin
            send_frame(short_length(), 1'b1, 1'b0, 0);
        end
        else if (pick < 95)
        begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
            begin
                // Keep noise free of the preamble so it stays noise.
                do
                    b = 8'($urandom_range(255));
                while (b == PREAMBLE);
                send_byte(b);
            end
        end
        else
        begin
            send_frame(short_length(), 1'b0, 1'b0, $urandom_range(3, 1));
        end
    endtask

    initial
    begin
        int phase_start;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        rst_n        = 1'b0;
        src_idle_pct = 16;
        rcv_idle_pct = 80;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme noise bytes, empty payload (type taken from CRC
        // bytes), one-byte payload, and a bad frame full of preambles that
        // must be consumed whole without resync.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 1'b0, 1'b0, 0);
        send_frame(1, 1'b0, 1'b0, 0);
        send_frame(2, 1'b1, 1'b1, 0);

        // Sender mostly busy, receiver mostly stalled.
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES)
            random_unit();

        // Swap: sender gappy, receiver mostly ready.
        src_idle_pct = 80;
        rcv_idle_pct = 16;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES)
            random_unit();

        // Full rate; run the one long frame here where it is cheap.
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        send_frame(LONG_LENGTH, 1'b0, 1'b0, 0);
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES)
            random_unit();

        s_tvalid <= 1'b0;

        // Drain every expected beat, then leave time for strays to show.
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/rfd_pkg.sv
rtl/rfd_crc24q.sv
rtl/rfd_core.sv
rtl/rtcm3_frame_deframer_crc24q_unit.sv
bench/rfd_tb_pkg.sv
bench/rfd_frame_checker.sv
bench/tb_rtcm3_frame_deframer_crc24q_unit.sv
